// File: rtl/tmtt_pkg.sv
// Package for the tempo map tick-to-time block.
// Holds request and response structs, segment entry type, codes and reset values.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package tmtt_pkg;

	localparam int REQ_W    = 2;
	localparam int TICK_W   = 32;
	localparam int TEMPO_W  = 24;
	localparam int TIME_W   = 56;
	localparam int PPQN_W   = 15;
	localparam int SEG_W    = 6;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// request kinds
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REWIND  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CONVERT = 2'd3;

	// response status
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PPQN          = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TEMPO = 1'b1;

	localparam logic [PPQN_W-1:0]  PPQN_RST  = 15'd96;
	localparam logic [TEMPO_W-1:0] TEMPO_RST = 24'd500000;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [TICK_W-1:0]  tick;
		logic [TEMPO_W-1:0] new_tempo;
	} req_t;

	typedef struct packed {
		logic [TIME_W-1:0]   time_us;
		logic [SEG_W-1:0]    segment;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [TICK_W-1:0]  tick;
		logic [TIME_W-1:0]  time_us;
		logic [TEMPO_W-1:0] tempo;
	} seg_t;

	// command into the multiply-divide unit
	typedef struct packed {
		logic               start;
		logic [TICK_W-1:0]  ticks;
		logic [TEMPO_W-1:0] tempo;
	} md_cmd_t;

endpackage

`default_nettype wire

// File: rtl/tmtt_muldiv.sv
// Multiply-divide unit: floor(ticks * tempo / ppqn), ppqn of zero taken as one.
// One registered 32x24 multiply, then a restoring divider retiring 4 bits a cycle.
// Depends on tmtt_pkg.
`default_nettype none

module tmtt_muldiv (
	input  wire                            clk,
	input  wire                            arst_n,
	input  tmtt_pkg::md_cmd_t              cmd,
	input  wire  [tmtt_pkg::PPQN_W-1:0]    ppqn,
	output logic                           done,
	output logic [tmtt_pkg::TIME_W-1:0]    quotient
);
	import tmtt_pkg::*;

	localparam int RB    = 4;
	localparam int STEPS = TIME_W / RB;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [TIME_W-1:0] quo_q;
	logic [PPQN_W-1:0] rem_q;
	logic [PPQN_W-1:0] dvsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TIME_W-1:0] quo_nxt;
	logic [PPQN_W-1:0] rem_nxt;

	// retire RB quotient bits, most significant first
	always_comb begin
		logic [PPQN_W:0] r;
		logic [RB-1:0]   qb;
		r  = {1'b0, rem_q};
		qb = '0;
		for (int k = 0; k < RB; k++) begin
			r = {r[PPQN_W-1:0], quo_q[TIME_W-1-k]};
			if (r >= {1'b0, dvsr_q}) begin
				r = r - {1'b0, dvsr_q};
				qb[RB-1-k] = 1'b1;
			end
		end
		rem_nxt = r[PPQN_W-1:0];
		quo_nxt = {quo_q[TIME_W-RB-1:0], qb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvsr_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (cmd.start) begin
				quo_q  <= TIME_W'(cmd.ticks) * TIME_W'(cmd.tempo);
				rem_q  <= '0;
				dvsr_q <= (ppqn == '0) ? PPQN_W'(1) : ppqn;
				cnt_q  <= CNT_W'(STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q <= quo_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: rtl/tempo_map_tick_to_time_top.sv
// Top level of the tempo map: converts ticks to microseconds over a segment table.
// Holds the segment memory, the hint walk sequencer and the response register.
// Depends on tmtt_pkg and tmtt_muldiv.
`default_nettype none

// Channel  | handshake            | payload            | direction
// ---------+----------------------+--------------------+----------
// request  | req_valid/req_stall  | req_data (req_t)   | in
// response | rsp_valid/rsp_stall  | rsp_data (rsp_t)   | out
// config   | cfg_we               | cfg_index,cfg_data | in
//
// One request at a time. Clear, rewind and a flagged append answer directly, an
// append runs the multiply-divide, a convert first compares later segment starts
// to the tick. The multiply-divide unit (load, then 14 steps of 4 quotient bits)
// sets the pace. Reset restores ppqn 96, default tempo 500000 and a one-segment
// map; no clearing pass, entry 0 lives in registers. A new request is taken while
// a response still waits under rsp_stall; its own response waits for the slot.

module tempo_map_tick_to_time_top #(
	parameter int MAX_SEGMENTS = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              req_valid,
	output logic                             req_stall,
	input  tmtt_pkg::req_t                   req_data,
	output logic                             rsp_valid,
	input  wire                              rsp_stall,
	output tmtt_pkg::rsp_t                   rsp_data,
	input  wire                              cfg_we,
	input  wire  [tmtt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [tmtt_pkg::CFG_W-1:0]       cfg_data
);
	import tmtt_pkg::*;

	localparam int IW   = $clog2(MAX_SEGMENTS);
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int SEXT = (IW > SEG_W) ? IW : SEG_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CUR  = 3'd1;
	localparam logic [2:0] S_NXT  = 3'd2;
	localparam logic [2:0] S_CALC = 3'd3;
	localparam logic [2:0] S_MD   = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	// configuration
	logic [PPQN_W-1:0]  ppqn_q;
	logic [TEMPO_W-1:0] dflt_tempo_q;

	// map state
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      hint_q;
	logic [TEMPO_W-1:0] seg0_tempo_q;
	seg_t               last_q;

	// sequencer
	logic [2:0]         state_q;
	req_t               req_q;
	seg_t               cur_q;
	logic [TIME_W-1:0]  base_q;
	rsp_t               res_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               rsp_load;

	// segment memory, entries 1 and up; entry 0 comes from registers
	seg_t               mem [MAX_SEGMENTS];
	logic [IW-1:0]      rd_addr;
	seg_t               rdata_q;
	logic               rd_zero_q;
	seg_t               rd_seg;
	logic               wr_en;

	md_cmd_t            md_cmd;
	logic               md_done;
	logic [TIME_W-1:0]  md_quo;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  sum_sat;
	logic               accept;
	logic [SEXT-1:0]    seg_ext;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);

	// load the response slot once it is free or being taken
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// address the hinted entry, then the ones after it
	always_comb begin
		case (state_q)
			S_CUR:   rd_addr = hint_q + IW'(1);
			S_NXT:   rd_addr = hint_q + IW'(2);
			default: rd_addr = hint_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IW-1:0]] <= '{tick: req_q.tick, time_us: sum_sat,
				tempo: req_q.new_tempo};
		end
		rdata_q   <= mem[rd_addr];
		rd_zero_q <= (rd_addr == '0);
	end

	assign rd_seg = rd_zero_q ? '{tick: '0, time_us: '0, tempo: seg0_tempo_q} : rdata_q;

	// launch the multiply-divide from the last segment or the hinted one
	always_comb begin
		md_cmd = '0;
		if (accept && req_data.req_type == REQ_APPEND && count_q != CW'(MAX_SEGMENTS)
				&& req_data.tick >= last_q.tick) begin
			md_cmd.start = 1'b1;
			md_cmd.ticks = req_data.tick - last_q.tick;
			md_cmd.tempo = last_q.tempo;
		end else if (state_q == S_CALC && req_q.tick >= cur_q.tick) begin
			md_cmd.start = 1'b1;
			md_cmd.ticks = req_q.tick - cur_q.tick;
			md_cmd.tempo = cur_q.tempo;
		end
	end

	tmtt_muldiv u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (md_cmd),
		.ppqn     (ppqn_q),
		.done     (md_done),
		.quotient (md_quo)
	);

	// base is always at most TIME_MAX, so a carry out means saturate
	assign sum     = {1'b0, base_q} + {1'b0, md_quo};
	assign sum_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	assign wr_en   = (state_q == S_MD) && md_done && (req_q.req_type == REQ_APPEND);
	assign seg_ext = SEXT'(hint_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppqn_q       <= PPQN_RST;
			dflt_tempo_q <= TEMPO_RST;
			count_q      <= CW'(1);
			hint_q       <= '0;
			seg0_tempo_q <= TEMPO_RST;
			last_q       <= '{tick: '0, time_us: '0, tempo: TEMPO_RST};
			state_q      <= S_IDLE;
			req_q        <= '0;
			cur_q        <= '0;
			base_q       <= '0;
			res_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PPQN:          ppqn_q       <= cfg_data[PPQN_W-1:0];
					CFG_DEFAULT_TEMPO: dflt_tempo_q <= cfg_data[TEMPO_W-1:0];
					default: ;
				endcase
			end

			// raise on a new response, drop the old one once taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= req_data;
						case (req_data.req_type)
							REQ_CLEAR: begin
								res_q        <= '0;
								count_q      <= CW'(1);
								hint_q       <= '0;
								seg0_tempo_q <= dflt_tempo_q;
								last_q       <= '{tick: '0, time_us: '0, tempo: dflt_tempo_q};
								state_q      <= S_DONE;
							end
							REQ_APPEND: begin
								base_q <= last_q.time_us;
								if (count_q == CW'(MAX_SEGMENTS)) begin
									res_q   <= '{time_us: '0, segment: '0, status: STAT_FULL};
									state_q <= S_DONE;
								end else if (req_data.tick < last_q.tick) begin
									res_q   <= '{time_us: '0, segment: '0, status: STAT_ORDER};
									state_q <= S_DONE;
								end else begin
									res_q   <= '0;
									state_q <= S_MD;
								end
							end
							REQ_REWIND: begin
								res_q   <= '0;
								hint_q  <= '0;
								state_q <= S_DONE;
							end
							default: begin
								res_q   <= '0;
								state_q <= S_CUR;
							end
						endcase
					end
				end
				S_CUR: begin
					cur_q <= rd_seg;
					if (CW'(hint_q) + CW'(1) < count_q) begin
						state_q <= S_NXT;
					end else begin
						state_q <= S_CALC;
					end
				end
				S_NXT: begin
					// advance past every start at or below the tick
					if (rd_seg.tick <= req_q.tick) begin
						cur_q  <= rd_seg;
						hint_q <= hint_q + IW'(1);
						if (!(CW'(hint_q) + CW'(2) < count_q)) begin
							state_q <= S_CALC;
						end
					end else begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					base_q <= cur_q.time_us;
					if (req_q.tick < cur_q.tick) begin
						res_q   <= '{time_us: '0, segment: seg_ext[SEG_W-1:0],
							status: STAT_ORDER};
						state_q <= S_DONE;
					end else begin
						res_q   <= '{time_us: '0, segment: seg_ext[SEG_W-1:0],
							status: STAT_OK};
						state_q <= S_MD;
					end
				end
				S_MD: begin
					if (md_done) begin
						if (req_q.req_type == REQ_APPEND) begin
							last_q  <= '{tick: req_q.tick, time_us: sum_sat,
								tempo: req_q.new_tempo};
							count_q <= count_q + CW'(1);
						end else begin
							res_q.time_us <= sum_sat;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the response slot is free
					if (rsp_load) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// the hint always points inside the filled part of the table
	assert property (@(posedge clk) disable iff (!arst_n)
		CW'(hint_q) < count_q)
		else $error("hint beyond segment count");

	// the table never holds zero or more than the maximum segments
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CW'(MAX_SEGMENTS)))
		else $error("segment count out of range");

	// a quotient only arrives while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == S_MD))
		else $error("multiply-divide result outside its wait state");

	// an accepted request stalls the request channel in the cycle after it
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request taken while another is in flight");

endmodule

`default_nettype wire
